// ----- rtl/fvnh_pkg.sv -----
// Shared types and constants for the fractal value-noise height core.
package fvnh_pkg;

   // fixed-point and table geometry
   localparam int FRAC_BITS  = 16;
   localparam int TABLE_SIZE = 256;
   localparam int TABLE_AW   = 8;
   localparam int ENTRY_W    = 8;
   localparam int NOISE_W    = ENTRY_W + FRAC_BITS;
   localparam int HEIGHT_W   = 8;

   // register widths and reset values
   localparam int FREQ_W     = 16;
   localparam int OCT_REG_W  = 4;
   localparam int MAXH_W     = 8;
   localparam int CSR_AW     = 2;
   localparam int CSR_DW     = 16;
   localparam logic [FREQ_W-1:0]    FREQ_RESET = 16'd3277;
   localparam logic [OCT_REG_W-1:0] OCT_RESET  = 4'd1;
   localparam logic [MAXH_W-1:0]    MAXH_RESET = 8'd20;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_FREQUENCY  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_OCTAVES    = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_MAX_HEIGHT = 2'd2;

   // request kinds
   localparam logic ACT_COMPUTE = 1'b0;
   localparam logic ACT_LOAD    = 1'b1;

   // pipeline depths
   localparam int LANE_LAT   = 5;
   localparam int DIV_STAGES = HEIGHT_W;

   // result buffer
   localparam int FIFO_DEPTH = 32;
   localparam int FIFO_AW    = 5;
   localparam int FIFO_CW    = 6;

   // table write broadcast to every table copy
   typedef struct packed {
      logic                en;
      logic [TABLE_AW-1:0] addr;
      logic [ENTRY_W-1:0]  data;
   } tbl_wr_type;

endpackage

// ----- rtl/fractal_value_noise_height_core.sv -----
// Top level: request intake, point scaling, octave lanes, octave sum, divider, result FIFO.
// Throughput: one request per cycle while the result FIFO has credit; each octave lane
// owns three table copies, so all corner reads of all octaves are made in the same cycle.
// Loads pass through two broadcast registers, then write every table copy; they give no result.
// Synchronous reset restores the registers to 3277/1/20 and empties the pipeline;
// table contents are undefined until loaded.
module fractal_value_noise_height_core #(
   parameter int COORD_BITS  = 10,
   parameter int MAX_OCTAVES = 8,
   localparam int REQ_DW = ((2*COORD_BITS + 2*fvnh_pkg::ENTRY_W + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [REQ_DW-1:0]             req_tdata,  // x_coord, z_coord, table_index, table_value
   input  logic                          req_tuser,  // action
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [fvnh_pkg::HEIGHT_W-1:0] rsp_tdata,  // height
   // register write port
   input  logic                          csr_we,
   input  logic [fvnh_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [fvnh_pkg::CSR_DW-1:0]   csr_wdata
);
   import fvnh_pkg::*;

   localparam int PW       = COORD_BITS + FREQ_W;
   localparam int SUM_W    = NOISE_W + MAX_OCTAVES;
   localparam int PROD_W   = SUM_W + MAXH_W;
   localparam int OCT_W    = $clog2(MAX_OCTAVES + 1);
   localparam int PIPE_LAT = 3 + LANE_LAT + DIV_STAGES;

   // configuration registers
   logic [FREQ_W-1:0]    freq_ff;
   logic [OCT_REG_W-1:0] oct_ff;
   logic [MAXH_W-1:0]    maxh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= FREQ_RESET;
         oct_ff  <= OCT_RESET;
         maxh_ff <= MAXH_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FREQUENCY:  freq_ff <= csr_wdata[FREQ_W-1:0];
            CSR_OCTAVES:    oct_ff  <= csr_wdata[OCT_REG_W-1:0];
            CSR_MAX_HEIGHT: maxh_ff <= csr_wdata[MAXH_W-1:0];
            default: ;
         endcase
      end
   end

   // effective octave count and its divisor mask 2^n-1
   logic [OCT_W-1:0]       nsat;
   logic [MAX_OCTAVES-1:0] dmask;
   always_comb begin
      if (oct_ff == '0) begin
         nsat = OCT_W'(1);
      end else if (int'(oct_ff) > MAX_OCTAVES) begin
         nsat = OCT_W'(MAX_OCTAVES);
      end else begin
         nsat = OCT_W'(oct_ff);
      end
   end
   assign dmask = {MAX_OCTAVES{1'b1}} >> (MAX_OCTAVES - int'(nsat));

   // request fields
   logic [COORD_BITS-1:0] x_coord, z_coord;
   logic [TABLE_AW-1:0]   table_index;
   logic [ENTRY_W-1:0]    table_value;
   logic                  req_xfer, cmp_xfer, rsp_xfer;
   assign x_coord     = req_tdata[0 +: COORD_BITS];
   assign z_coord     = req_tdata[COORD_BITS +: COORD_BITS];
   assign table_index = req_tdata[2*COORD_BITS +: TABLE_AW];
   assign table_value = req_tdata[2*COORD_BITS + TABLE_AW +: ENTRY_W];
   assign req_xfer    = req_tvalid && req_tready;
   assign cmp_xfer    = req_xfer && (req_tuser == ACT_COMPUTE);
   assign rsp_xfer    = rsp_tvalid && rsp_tready;

   // table load broadcast, delayed through two registers: computes ahead of the load
   // finish their lookups first, computes behind it see the new entry
   tbl_wr_type tbl_wr_in, tbl_wr1_ff, tbl_wr2_ff;
   assign tbl_wr_in.en   = req_xfer && (req_tuser == ACT_LOAD);
   assign tbl_wr_in.addr = table_index;
   assign tbl_wr_in.data = table_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_wr1_ff <= '0;
         tbl_wr2_ff <= '0;
      end else begin
         tbl_wr1_ff <= tbl_wr_in;
         tbl_wr2_ff <= tbl_wr1_ff;
      end
   end

   // valid tracking for compute requests
   logic [PIPE_LAT:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_LAT-1:0], cmp_xfer};
      end
   end

   // point scaling
   logic [COORD_BITS-1:0] x1_ff, z1_ff;
   logic [PW-1:0]         px2_ff, pz2_ff;
   always_ff @(posedge clock) begin
      x1_ff  <= x_coord;
      z1_ff  <= z_coord;
      px2_ff <= PW'(x1_ff) * PW'(freq_ff);
      pz2_ff <= PW'(z1_ff) * PW'(freq_ff);
   end

   // octave lanes
   logic [NOISE_W-1:0] noise [MAX_OCTAVES];
   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
      fvnh_octave #(.PW(PW), .OCTAVE(k)) u_octave (
         .clock  (clock),
         .tbl_wr (tbl_wr2_ff),
         .px     (px2_ff),
         .pz     (pz2_ff),
         .noise  (noise[k])
      );
   end

   // weighted octave sum: fixed weights for the full octave count, then one
   // right shift for the active count; scaling by max_height follows
   logic [SUM_W-1:0]  sum_all, sum_c, sum_ff;
   logic [PROD_W-1:0] prod_ff;
   always_comb begin
      sum_all = '0;
      for (int k = 0; k < MAX_OCTAVES; k++) begin
         if (k < int'(nsat)) begin
            sum_all = sum_all + (SUM_W'(noise[k]) << (MAX_OCTAVES - 1 - k));
         end
      end
   end
   assign sum_c = sum_all >> (MAX_OCTAVES - int'(nsat));

   always_ff @(posedge clock) begin
      sum_ff  <= sum_c;
      prod_ff <= PROD_W'(sum_ff) * PROD_W'(maxh_ff);
   end

   logic [HEIGHT_W-1:0] height;
   fvnh_div #(.PROD_W(PROD_W), .MAX_OCTAVES(MAX_OCTAVES)) u_div (
      .clock    (clock),
      .dividend (prod_ff),
      .dmask    (dmask),
      .quotient (height)
   );

   // result FIFO; credits cover every compute in flight
   logic [HEIGHT_W-1:0] fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CW-1:0]  fill_ff, pend_ff;
   logic                fifo_wr;
   assign fifo_wr = vld_ff[PIPE_LAT];

   always_ff @(posedge clock) begin
      if (fifo_wr) begin
         fifo_mem[wr_ptr_ff] <= height;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         pend_ff   <= '0;
      end else begin
         if (fifo_wr) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (rsp_xfer) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         fill_ff <= fill_ff + FIFO_CW'(fifo_wr) - FIFO_CW'(rsp_xfer);
         pend_ff <= pend_ff + FIFO_CW'(cmp_xfer) - FIFO_CW'(rsp_xfer);
      end
   end

   assign req_tready = pend_ff < FIFO_CW'(FIFO_DEPTH);
   assign rsp_tvalid = fill_ff != '0;
   assign rsp_tdata  = fifo_mem[rd_ptr_ff];

   // checks
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= FIFO_CW'(FIFO_DEPTH)) else $error("credit count overflow");

   a_fill_le_pend: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= pend_ff) else $error("FIFO holds more than issued");

   a_no_full_write: assert property (@(posedge clock) disable iff (reset)
      fifo_wr |-> fill_ff != FIFO_CW'(FIFO_DEPTH)) else $error("write into full FIFO");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tuser == ACT_LOAD) |=> !vld_ff[0])
      else $error("load started a result");

endmodule

// ----- rtl/fvnh_ram.sv -----
// Generic RAM: one write port, two registered read ports, read-first.
module fvnh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ----- rtl/fvnh_octave.sv -----
// One octave lane: two-level table lookup, smoothstep weights and bilinear blend.
module fvnh_octave #(
   parameter int PW     = 26,
   parameter int OCTAVE = 0
) (
   input  logic                       clock,
   input  fvnh_pkg::tbl_wr_type       tbl_wr,
   input  logic [PW-1:0]              px,
   input  logic [PW-1:0]              pz,
   output logic [fvnh_pkg::NOISE_W-1:0] noise
);
   import fvnh_pkg::*;

   localparam int SHW  = PW + OCTAVE + ENTRY_W;
   localparam int W_W  = FRAC_BITS + 1;
   localparam int LO_W = ENTRY_W + FRAC_BITS + 2;
   localparam int V_W  = LO_W + FRAC_BITS + 1;

   // cell and fraction of the octave-scaled point
   logic [SHW-1:0]       shx, shz;
   logic [TABLE_AW-1:0]  cx, cz;
   assign shx = SHW'(px) << OCTAVE;
   assign shz = SHW'(pz) << OCTAVE;
   assign cx  = shx[FRAC_BITS +: TABLE_AW];
   assign cz  = shz[FRAC_BITS +: TABLE_AW];

   // first-level lookup of rows cz and cz+1
   logic [ENTRY_W-1:0] row0, row1;
   fvnh_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_row (
      .clock     (clock),
      .wr_en     (tbl_wr.en),
      .wr_addr   (tbl_wr.addr),
      .wr_data   (tbl_wr.data),
      .rd_addr_a (cz),
      .rd_addr_b (cz + TABLE_AW'(1)),
      .rd_data_a (row0),
      .rd_data_b (row1)
   );

   logic [TABLE_AW-1:0]  cx3_ff;
   logic [FRAC_BITS-1:0] sx3_ff, sz3_ff, sx4_ff, sz4_ff;
   logic [2*FRAC_BITS-1:0] sqx4_ff, sqz4_ff;

   // second-level lookup of the four corners
   logic [TABLE_AW-1:0] a0_addr, c0_addr;
   logic [ENTRY_W-1:0]  ca, cb, cc, cd;
   assign a0_addr = row0 + cx3_ff;
   assign c0_addr = row1 + cx3_ff;

   fvnh_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_lo (
      .clock     (clock),
      .wr_en     (tbl_wr.en),
      .wr_addr   (tbl_wr.addr),
      .wr_data   (tbl_wr.data),
      .rd_addr_a (a0_addr),
      .rd_addr_b (a0_addr + TABLE_AW'(1)),
      .rd_data_a (ca),
      .rd_data_b (cb)
   );

   fvnh_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_hi (
      .clock     (clock),
      .wr_en     (tbl_wr.en),
      .wr_addr   (tbl_wr.addr),
      .wr_data   (tbl_wr.data),
      .rd_addr_a (c0_addr),
      .rd_addr_b (c0_addr + TABLE_AW'(1)),
      .rd_data_a (cc),
      .rd_data_b (cd)
   );

   // smoothstep: s2 = s*s >> F, w = s2 * (3*2^F - 2s) >> F
   logic [FRAC_BITS-1:0]   s2x, s2z;
   logic [FRAC_BITS+1:0]   tx, tz;
   logic [3*FRAC_BITS+1:0] wpx, wpz;
   assign s2x = sqx4_ff[2*FRAC_BITS-1:FRAC_BITS];
   assign s2z = sqz4_ff[2*FRAC_BITS-1:FRAC_BITS];
   assign tx  = (FRAC_BITS+2)'(3) * (FRAC_BITS+2)'(1 << FRAC_BITS)
                - {1'b0, sx4_ff, 1'b0};
   assign tz  = (FRAC_BITS+2)'(3) * (FRAC_BITS+2)'(1 << FRAC_BITS)
                - {1'b0, sz4_ff, 1'b0};
   assign wpx = (3*FRAC_BITS+2)'(s2x) * (3*FRAC_BITS+2)'(tx);
   assign wpz = (3*FRAC_BITS+2)'(s2z) * (3*FRAC_BITS+2)'(tz);

   logic [W_W-1:0]     wx5_ff, wz5_ff, wz6_ff;
   logic [ENTRY_W-1:0] a5_ff, b5_ff, c5_ff, d5_ff;

   // blend along x
   logic signed [W_W:0]       wxs;
   logic signed [ENTRY_W:0]   dab, dcd;
   logic signed [LO_W-1:0]    lo_c, hi_c, lo6_ff, hi6_ff;
   assign wxs  = $signed({1'b0, wx5_ff});
   assign dab  = $signed({1'b0, b5_ff}) - $signed({1'b0, a5_ff});
   assign dcd  = $signed({1'b0, d5_ff}) - $signed({1'b0, c5_ff});
   assign lo_c = LO_W'($signed({2'b00, a5_ff, {FRAC_BITS{1'b0}}})) + LO_W'(wxs * dab);
   assign hi_c = LO_W'($signed({2'b00, c5_ff, {FRAC_BITS{1'b0}}})) + LO_W'(wxs * dcd);

   // blend along z
   logic signed [W_W:0]   wzs;
   logic signed [LO_W:0]  dhl;
   logic signed [V_W-1:0] v_c;
   assign wzs = $signed({1'b0, wz6_ff});
   assign dhl = (LO_W+1)'(hi6_ff) - (LO_W+1)'(lo6_ff);
   assign v_c = V_W'($signed({lo6_ff, {FRAC_BITS{1'b0}}})) + V_W'(wzs * dhl);

   logic [NOISE_W-1:0] noise_ff;
   assign noise = noise_ff;

   always_ff @(posedge clock) begin
      cx3_ff   <= cx;
      sx3_ff   <= shx[FRAC_BITS-1:0];
      sz3_ff   <= shz[FRAC_BITS-1:0];
      sqx4_ff  <= (2*FRAC_BITS)'(sx3_ff) * (2*FRAC_BITS)'(sx3_ff);
      sqz4_ff  <= (2*FRAC_BITS)'(sz3_ff) * (2*FRAC_BITS)'(sz3_ff);
      sx4_ff   <= sx3_ff;
      sz4_ff   <= sz3_ff;
      wx5_ff   <= wpx[FRAC_BITS +: W_W];
      wz5_ff   <= wpz[FRAC_BITS +: W_W];
      a5_ff    <= ca;
      b5_ff    <= cb;
      c5_ff    <= cc;
      d5_ff    <= cd;
      lo6_ff   <= lo_c;
      hi6_ff   <= hi_c;
      wz6_ff   <= wz5_ff;
      noise_ff <= v_c[FRAC_BITS +: NOISE_W];
   end

endmodule

// ----- rtl/fvnh_div.sv -----
// Pipelined restoring divider: sum*max_height over (2^n-1) << 24, one quotient bit a stage.
module fvnh_div #(
   parameter int PROD_W      = 40,
   parameter int MAX_OCTAVES = 8
) (
   input  logic                          clock,
   input  logic [PROD_W-1:0]             dividend,
   input  logic [MAX_OCTAVES-1:0]        dmask,
   output logic [fvnh_pkg::HEIGHT_W-1:0] quotient
);
   import fvnh_pkg::*;

   logic [PROD_W-1:0]   rem_ff [DIV_STAGES];
   logic [HEIGHT_W-1:0] q_ff   [DIV_STAGES];

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic [PROD_W-1:0]   rem_in, cmp;
      logic [HEIGHT_W-1:0] q_in;
      logic                take;
      if (i == 0) begin : g_first
         assign rem_in = dividend;
         assign q_in   = '0;
      end else begin : g_next
         assign rem_in = rem_ff[i-1];
         assign q_in   = q_ff[i-1];
      end
      // divisor aligned to quotient bit HEIGHT_W-1-i
      assign cmp  = PROD_W'(dmask) << (FRAC_BITS + ENTRY_W + DIV_STAGES - 1 - i);
      assign take = rem_in >= cmp;
      always_ff @(posedge clock) begin
         rem_ff[i] <= take ? rem_in - cmp : rem_in;
         q_ff[i]   <= {q_in[HEIGHT_W-2:0], take};
      end
   end

   assign quotient = q_ff[DIV_STAGES-1];

endmodule
